// ----- rtl/rsv_pkg.sv -----
// Shared constants, types and helper functions for the record slot validator.
package rsv_pkg;

  localparam int SLOT_BYTES   = 256;
  localparam int HEADER_BYTES = 17;
  localparam int MAGIC_BYTES  = 4;
  localparam int VERSION_POS  = 4;
  localparam int LENGTH_POS   = 5;
  localparam int SEQ_POS      = 9;
  localparam int CRC_BYTES    = 4;
  localparam int LEN_LIMIT    = SLOT_BYTES - 1 - HEADER_BYTES - CRC_BYTES;

  // Position saturates at SLOT_BYTES + 1.
  localparam int POS_W = $clog2(SLOT_BYTES + 2);
  localparam int COV_W = 33;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL  = 32'hFFFFFFFF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int MAXP_W     = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_VALUE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASED_VALUE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 2'd3;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_TRUNCATED   = 3'd1,
    ERR_EMPTY       = 3'd2,
    ERR_UNCOMMITTED = 3'd3,
    ERR_MAGIC       = 3'd4,
    ERR_VERSION     = 3'd5,
    ERR_LENGTH      = 3'd6,
    ERR_CRC         = 3'd7
  } rsv_err_e;

  typedef enum logic [1:0] {
    REC_RECOVERED   = 2'd0,
    REC_NO_RECORD   = 2'd1,
    REC_CORRUPTION  = 2'd2
  } rsv_rec_e;

  typedef struct packed {
    logic [7:0]        expected_version;
    logic [7:0]        commit_value;
    logic [7:0]        erased_value;
    logic [MAXP_W-1:0] max_payload;
  } rsv_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [31:0]      crc;
    logic [31:0]      latched;
    logic [31:0]      stored;
    logic [31:0]      length;
    logic [63:0]      seq;
    logic             erased;
    logic             magic_bad;
    logic             version_bad;
    logic [7:0]       commit;
  } rsv_slot_t;

  localparam rsv_slot_t SLOT_CLEAR = '{
    pos:         '0,
    crc:         CRC_ALL,
    latched:     '0,
    stored:      '0,
    length:      '0,
    seq:         '0,
    erased:      1'b1,
    magic_bad:   1'b0,
    version_bad: 1'b0,
    commit:      '0
  };

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h42;
      2'd1:    val = 8'h52;
      2'd2:    val = 8'h4C;
      default: val = 8'h31;
    endcase
    return val;
  endfunction

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic length_ok(input logic [31:0] len, input logic [MAXP_W-1:0] maxp);
    return (len <= {{(32-MAXP_W){1'b0}}, maxp}) && (len <= 32'(LEN_LIMIT));
  endfunction

endpackage

// ----- rtl/record_slot_validator_crc32_top.sv -----
// Top level of the record slot validator: input register, configuration and wiring.
//
// Input channel: one slot byte per item (slot_byte_i) with is_last_i on the
// final byte read; accepted when in_valid_i is high and in_stall_o is low.
// Output channel: one item per payload byte that lies inside a valid length
// (kind_o 0, payload_byte_o), and one verdict item (kind_o 1) for the byte
// flagged last, carrying error_code_o, recovery_class_o and, on success,
// sequence_res_o and payload_length_o. Items that yield no result vanish.
// An accepted item is held in the input register and moves into the result
// register when it steps on, which a stalled receiver can hold off.
// Throughput: one item per cycle while the receiver does not stall; the CRC-32
// byte step and all checks settle between the two registers.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall_o then rises until out_stall_i drops.
// Users write configuration (cfg_we_i, cfg_index_i, cfg_data_i) only while idle;
// the block does not enforce it. Reset clears both valid bits and the slot state;
// registers return to version 1, commit 0x00, erased 0xFF, max payload 234.
module record_slot_validator_crc32_top import rsv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            slot_byte_i,
  input  logic                  is_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  kind_o,
  output logic [7:0]            payload_byte_o,
  output logic [2:0]            error_code_o,
  output logic [1:0]            recovery_class_o,
  output logic [63:0]           sequence_res_o,
  output logic [MAXP_W-1:0]     payload_length_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  rsv_cfg_t  cfg_q;
  logic      in_valid_q;
  logic [7:0] in_byte_q;
  logic      in_last_q;
  logic      step;
  logic      accept;
  logic      emit;
  rsv_slot_t nxt;

  // Advance the held item whenever the result register is free or draining.
  assign step       = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= slot_byte_i;
      in_last_q <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= 8'd1;
      cfg_q.commit_value     <= 8'd0;
      cfg_q.erased_value     <= 8'hFF;
      cfg_q.max_payload      <= MAXP_W'(234);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_data_i[7:0];
        CFG_COMMIT_VALUE:     cfg_q.commit_value     <= cfg_data_i[7:0];
        CFG_ERASED_VALUE:     cfg_q.erased_value     <= cfg_data_i[7:0];
        CFG_MAX_PAYLOAD:      cfg_q.max_payload      <= cfg_data_i[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  rsv_slot_state u_slot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg_q),
    .nxt_o  (nxt),
    .emit_o (emit)
  );

  rsv_verdict u_verdict (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .byte_i           (in_byte_q),
    .last_i           (in_last_q),
    .emit_i           (emit),
    .nxt_i            (nxt),
    .cfg_i            (cfg_q),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .error_code_o     (error_code_o),
    .recovery_class_o (recovery_class_o),
    .sequence_res_o   (sequence_res_o),
    .payload_length_o (payload_length_o)
  );

endmodule

// ----- rtl/rsv_slot_state.sv -----
// Per-slot state: byte position, CRC, header fields and check flags.
module rsv_slot_state import rsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic [7:0] byte_i,
  input  logic      last_i,
  input  rsv_cfg_t  cfg_i,
  output rsv_slot_t nxt_o,
  output logic      emit_o
);

  rsv_slot_t state_q;
  rsv_slot_t state_d;
  logic [COV_W-1:0] covered;
  logic [COV_W-1:0] pos_ext;
  logic [31:0] crc_new;

  always_comb begin
    state_d = state_q;
    emit_o  = 1'b0;
    covered = COV_W'(HEADER_BYTES) + {1'b0, state_q.length};
    pos_ext = COV_W'(state_q.pos);
    crc_new = crc_byte(state_q.crc, byte_i);
    if (state_q.pos < POS_W'(SLOT_BYTES)) begin
      if (byte_i != cfg_i.erased_value) begin
        state_d.erased = 1'b0;
      end
      if (state_q.pos < POS_W'(MAGIC_BYTES)) begin
        if (byte_i != magic_byte(state_q.pos[1:0])) begin
          state_d.magic_bad = 1'b1;
        end
      end else if (state_q.pos == POS_W'(VERSION_POS)) begin
        if (byte_i != cfg_i.expected_version) begin
          state_d.version_bad = 1'b1;
        end
      end else if (state_q.pos < POS_W'(SEQ_POS)) begin
        for (int i = 0; i < 4; i++) begin
          if (state_q.pos == POS_W'(LENGTH_POS + i)) begin
            state_d.length[8*i +: 8] = state_q.length[8*i +: 8] | byte_i;
          end
        end
      end else if (state_q.pos < POS_W'(HEADER_BYTES)) begin
        for (int i = 0; i < 8; i++) begin
          if (state_q.pos == POS_W'(SEQ_POS + i)) begin
            state_d.seq[8*i +: 8] = state_q.seq[8*i +: 8] | byte_i;
          end
        end
      end
      if (pos_ext < covered) begin
        state_d.crc = crc_new;
        if (pos_ext + COV_W'(1) == covered) begin
          state_d.latched = crc_new ^ CRC_ALL;
        end
        if (state_q.pos >= POS_W'(HEADER_BYTES) &&
            length_ok(state_q.length, cfg_i.max_payload)) begin
          emit_o = 1'b1;
        end
      end else if (pos_ext < covered + COV_W'(CRC_BYTES)) begin
        // Stored CRC is little-endian: shift in from the top.
        state_d.stored = {byte_i, state_q.stored[31:8]};
      end
      if (state_q.pos == POS_W'(SLOT_BYTES - 1)) begin
        state_d.commit = byte_i;
      end
    end
    if (state_q.pos < POS_W'(SLOT_BYTES + 1)) begin
      state_d.pos = state_q.pos + POS_W'(1);
    end
  end

  assign nxt_o = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLOT_CLEAR;
    end else if (step_i) begin
      // A verdict ends the slot.
      state_q <= last_i ? SLOT_CLEAR : state_d;
    end
  end

endmodule

// ----- rtl/rsv_verdict.sv -----
// Verdict decision and output register for result items.
module rsv_verdict import rsv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic              emit_i,
  input  rsv_slot_t         nxt_i,
  input  rsv_cfg_t          cfg_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              kind_o,
  output logic [7:0]        payload_byte_o,
  output logic [2:0]        error_code_o,
  output logic [1:0]        recovery_class_o,
  output logic [63:0]       sequence_res_o,
  output logic [MAXP_W-1:0] payload_length_o
);

  rsv_err_e code;
  rsv_rec_e rec;

  logic              valid_q, valid_d;
  logic              kind_q;
  logic [7:0]        pbyte_q;
  rsv_err_e          code_q;
  rsv_rec_e          rec_q;
  logic [63:0]       seq_q;
  logic [MAXP_W-1:0] len_q;

  always_comb begin
    if (nxt_i.pos != POS_W'(SLOT_BYTES)) begin
      code = ERR_TRUNCATED;
    end else if (nxt_i.erased) begin
      code = ERR_EMPTY;
    end else if (nxt_i.commit != cfg_i.commit_value) begin
      code = ERR_UNCOMMITTED;
    end else if (nxt_i.magic_bad) begin
      code = ERR_MAGIC;
    end else if (nxt_i.version_bad) begin
      code = ERR_VERSION;
    end else if (!length_ok(nxt_i.length, cfg_i.max_payload)) begin
      code = ERR_LENGTH;
    end else if (nxt_i.stored != nxt_i.latched) begin
      code = ERR_CRC;
    end else begin
      code = ERR_NONE;
    end
    unique case (code) inside
      ERR_NONE:                   rec = REC_RECOVERED;
      ERR_EMPTY, ERR_UNCOMMITTED: rec = REC_NO_RECORD;
      default:                    rec = REC_CORRUPTION;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = last_i | emit_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      kind_q  <= last_i;
      pbyte_q <= last_i ? 8'd0 : byte_i;
      code_q  <= last_i ? code : ERR_NONE;
      rec_q   <= last_i ? rec : REC_RECOVERED;
      seq_q   <= (last_i && code == ERR_NONE) ? nxt_i.seq : 64'd0;
      len_q   <= (last_i && code == ERR_NONE) ? nxt_i.length[MAXP_W-1:0] : '0;
    end
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = kind_q;
  assign payload_byte_o   = pbyte_q;
  assign error_code_o     = code_q;
  assign recovery_class_o = rec_q;
  assign sequence_res_o   = seq_q;
  assign payload_length_o = len_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the record slot validator top level.
module testbench;
  import rsv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned QUIET_FROM  = 300;
  localparam int unsigned QUIET_TO    = 700;
  localparam int unsigned HOLD_AT     = 600;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned ITEM_GOAL   = 1050;
  localparam int unsigned SETTLE      = 8;

  typedef struct {
    logic              kind;
    logic [7:0]        data;
    rsv_err_e          code;
    rsv_rec_e          rec;
    logic [63:0]       seq;
    logic [MAXP_W-1:0] len;
  } slot_result_t;

  // Tracks one slot at a time and queues the results it should produce.
  class slot_verdicts;
    logic [7:0]        want_version;
    logic [7:0]        commit_val;
    logic [7:0]        erased_val;
    logic [MAXP_W-1:0] max_len;
    int unsigned       pos;
    logic [31:0]       crc_run;
    logic [31:0]       crc_latched;
    logic [31:0]       crc_stored;
    logic [31:0]       len_word;
    logic [63:0]       seq_word;
    bit                all_erased;
    bit                magic_bad;
    bit                version_bad;
    logic [7:0]        commit_seen;
    slot_result_t      pending_results[$];
    int unsigned       fails;

    function new();
      want_version = 8'd1;
      commit_val   = 8'h00;
      erased_val   = 8'hFF;
      max_len      = 12'd234;
      fails        = 0;
      clear_slot();
    endfunction

    function void clear_slot();
      pos         = 0;
      crc_run     = CRC_ALL;
      crc_latched = '0;
      crc_stored  = '0;
      len_word    = '0;
      seq_word    = '0;
      all_erased  = 1'b1;
      magic_bad   = 1'b0;
      version_bad = 1'b0;
      commit_seen = '0;
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      return r;
    endfunction

    function bit len_fits();
      return (len_word <= 32'(max_len)) && (len_word <= 32'(LEN_LIMIT));
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_EXPECTED_VERSION: want_version = val[7:0];
        CFG_COMMIT_VALUE:     commit_val   = val[7:0];
        CFG_ERASED_VALUE:     erased_val   = val[7:0];
        CFG_MAX_PAYLOAD:      max_len      = val[MAXP_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_byte(logic [7:0] b, bit last);
      logic [32:0]  body_end;
      logic [31:0]  magic_word;
      slot_result_t r;
      bit           emit;
      magic_word = "BRL1";
      emit = 1'b0;
      if (pos < SLOT_BYTES) begin
        if (b != erased_val) all_erased = 1'b0;
        if (pos < MAGIC_BYTES) begin
          if (b != magic_word[8*(3-pos) +: 8]) magic_bad = 1'b1;
        end else if (pos == VERSION_POS) begin
          if (b != want_version) version_bad = 1'b1;
        end else if (pos < SEQ_POS) begin
          len_word |= 32'(b) << (8 * (pos - LENGTH_POS));
        end else if (pos < HEADER_BYTES) begin
          seq_word |= 64'(b) << (8 * (pos - SEQ_POS));
        end
        body_end = 33'(HEADER_BYTES) + 33'(len_word);
        if (33'(pos) < body_end) begin
          crc_run = crc_step(crc_run, b);
          if (33'(pos) + 33'd1 == body_end) crc_latched = ~crc_run;
          if (pos >= HEADER_BYTES && len_fits()) emit = 1'b1;
        end else if (33'(pos) < body_end + 33'd4) begin
          crc_stored = {b, crc_stored[31:8]};
        end
        if (pos == SLOT_BYTES - 1) commit_seen = b;
      end
      // Count past the slot end only far enough to flag truncation.
      if (pos <= SLOT_BYTES) pos++;
      if (last) begin
        if (pos != SLOT_BYTES)              r.code = ERR_TRUNCATED;
        else if (all_erased)                r.code = ERR_EMPTY;
        else if (commit_seen != commit_val) r.code = ERR_UNCOMMITTED;
        else if (magic_bad)                 r.code = ERR_MAGIC;
        else if (version_bad)               r.code = ERR_VERSION;
        else if (!len_fits())               r.code = ERR_LENGTH;
        else if (crc_stored != crc_latched) r.code = ERR_CRC;
        else                                r.code = ERR_NONE;
        if (r.code == ERR_NONE)
          r.rec = REC_RECOVERED;
        else if (r.code == ERR_EMPTY || r.code == ERR_UNCOMMITTED)
          r.rec = REC_NO_RECORD;
        else
          r.rec = REC_CORRUPTION;
        r.kind = 1'b1;
        r.data = '0;
        r.seq  = (r.code == ERR_NONE) ? seq_word : '0;
        r.len  = (r.code == ERR_NONE) ? len_word[MAXP_W-1:0] : '0;
        pending_results.push_back(r);
        clear_slot();
      end else if (emit) begin
        r.kind = 1'b0;
        r.data = b;
        r.code = ERR_NONE;
        r.rec  = REC_RECOVERED;
        r.seq  = '0;
        r.len  = '0;
        pending_results.push_back(r);
      end
    endfunction

    function void match_result(slot_result_t got);
      slot_result_t want;
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: kind=%0d byte=%02h code=%0d class=%0d",
                   got.kind, got.data, got.code, got.rec);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.code !== want.code ||
          got.rec !== want.rec || got.seq !== want.seq || got.len !== want.len) begin
        fails++;
        if (fails <= 10) begin
          $display("mismatch: expected kind=%0d byte=%02h code=%0d class=%0d seq=%016h len=%0d",
                   want.kind, want.data, want.code, want.rec, want.seq, want.len);
          $display("          actual   kind=%0d byte=%02h code=%0d class=%0d seq=%016h len=%0d",
                   got.kind, got.data, got.code, got.rec, got.seq, got.len);
        end
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            slot_byte_i = '0;
  logic                  is_last_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  kind_o;
  logic [7:0]            payload_byte_o;
  logic [2:0]            error_code_o;
  logic [1:0]            recovery_class_o;
  logic [63:0]           sequence_res_o;
  logic [MAXP_W-1:0]     payload_length_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  slot_verdicts  board;
  slot_result_t  seen_result;
  logic [7:0]    slot_img [SLOT_BYTES];
  int unsigned   cyc = 0;
  int unsigned   sent_items = 0;
  int unsigned   hold_left = 0;
  bit            hold_done = 1'b0;

  record_slot_validator_crc32_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .slot_byte_i      (slot_byte_i),
    .is_last_i        (is_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .error_code_o     (error_code_o),
    .recovery_class_o (recovery_class_o),
    .sequence_res_o   (sequence_res_o),
    .payload_length_o (payload_length_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit quiet_now();
    return cyc >= QUIET_FROM && cyc < QUIET_TO;
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && sent_items >= HOLD_AT) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_now() && ($urandom_range(0, 99) < 33);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_result.kind = kind_o;
      seen_result.data = payload_byte_o;
      seen_result.code = rsv_err_e'(error_code_o);
      seen_result.rec  = rsv_rec_e'(recovery_class_o);
      seen_result.seq  = sequence_res_o;
      seen_result.len  = payload_length_o;
      board.match_result(seen_result);
    end
  end

  task automatic send_item(input logic [7:0] b, input bit last);
    while (!quiet_now() && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    slot_byte_i <= b;
    is_last_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.predict_byte(b, last);
    sent_items++;
  endtask

  // Send slot bytes [from, upto); bytes past the slot end are random.
  task automatic stream_slot(input int from, input int upto, input bit close);
    for (int i = from; i < upto; i++)
      send_item(i < SLOT_BYTES ? slot_img[i] : 8'($urandom), close && i == upto - 1);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  // Upper bits of the 8-bit registers get junk; the block keeps only the low byte.
  task automatic write_config(input logic [7:0] ver, input logic [7:0] com,
                              input logic [7:0] ers, input logic [MAXP_W-1:0] maxp);
    write_reg(CFG_EXPECTED_VERSION, {4'($urandom), ver});
    write_reg(CFG_COMMIT_VALUE, {4'($urandom), com});
    write_reg(CFG_ERASED_VALUE, {4'($urandom), ers});
    write_reg(CFG_MAX_PAYLOAD, maxp);
    cfg_we_i <= 1'b0;
  endtask

  task automatic build_record(input logic [31:0] len, input bit erased_fill);
    logic [31:0] crc;
    logic [63:0] seq;
    logic [32:0] body_end;
    logic [31:0] magic_word;
    magic_word = "BRL1";
    seq        = {$urandom, $urandom};
    crc        = CRC_ALL;
    body_end   = 33'(HEADER_BYTES) + 33'(len);
    for (int i = 0; i < SLOT_BYTES; i++)
      slot_img[i] = erased_fill ? board.erased_val : 8'($urandom);
    for (int i = 0; i < MAGIC_BYTES; i++) slot_img[i] = magic_word[8*(3-i) +: 8];
    slot_img[VERSION_POS] = board.want_version;
    for (int i = 0; i < 4; i++) slot_img[LENGTH_POS+i] = len[8*i +: 8];
    for (int i = 0; i < 8; i++) slot_img[SEQ_POS+i] = seq[8*i +: 8];
    for (int i = HEADER_BYTES; i < SLOT_BYTES && 33'(i) < body_end; i++)
      slot_img[i] = 8'($urandom);
    for (int i = 0; i < SLOT_BYTES && 33'(i) < body_end; i++)
      crc = slot_verdicts::crc_step(crc, slot_img[i]);
    crc = ~crc;
    for (int i = 0; i < 4; i++)
      if (body_end + 33'(i) < 33'(SLOT_BYTES)) slot_img[body_end + 33'(i)] = crc[8*i +: 8];
    slot_img[SLOT_BYTES-1] = board.commit_val;
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    return (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
  endfunction

  task automatic random_slot();
    int unsigned pick;
    int unsigned cap;
    int unsigned count;
    logic [31:0] len;
    cap = (board.max_len < LEN_LIMIT) ? board.max_len : LEN_LIMIT;
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = cap;
      2:       len = cap + 1;
      3:       len = $urandom;
      4:       len = $urandom_range(LEN_LIMIT + 1, LEN_LIMIT + 6);
      default: len = $urandom_range(0, cap);
    endcase
    build_record(len, 1'($urandom_range(0, 1)));
    count = SLOT_BYTES;
    pick  = $urandom_range(0, 99);
    if (pick < 40) begin
      // leave the record intact
    end else if (pick < 48) begin
      slot_img[$urandom_range(0, MAGIC_BYTES - 1)] ^= 8'($urandom_range(1, 255));
    end else if (pick < 54) begin
      slot_img[VERSION_POS] ^= 8'($urandom_range(1, 255));
    end else if (pick < 62) begin
      slot_img[SLOT_BYTES-1] ^= 8'($urandom_range(1, 255));
    end else if (pick < 72) begin
      slot_img[$urandom_range(LENGTH_POS, SLOT_BYTES - 2)] ^= 8'($urandom_range(1, 255));
    end else if (pick < 78) begin
      foreach (slot_img[i]) slot_img[i] = board.erased_val;
    end else if (pick < 84) begin
      foreach (slot_img[i]) slot_img[i] = 8'($urandom);
    end else if (pick < 94) begin
      count = $urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(1, SLOT_BYTES - 1);
    end else begin
      count = $urandom_range(SLOT_BYTES + 1, SLOT_BYTES + 6);
    end
    stream_slot(0, count, 1'b1);
  endtask

  initial begin
    logic [MAXP_W-1:0] maxp;
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed slots under the reset register values.
    send_item(8'h42, 1'b1);
    build_record(LEN_LIMIT, 1'b0);
    stream_slot(0, SLOT_BYTES, 1'b1);
    wait_quiet();

    // Change commit and length limit halfway through a record's payload.
    write_config(8'hFF, 8'hFF, 8'h00, '0);
    build_record(50, 1'b0);
    stream_slot(0, 40, 1'b0);
    wait_quiet();
    write_config(8'hFF, 8'h5A, 8'h00, 12'd4075);
    slot_img[SLOT_BYTES-1] = 8'h5A;
    stream_slot(40, SLOT_BYTES, 1'b1);
    wait_quiet();

    while (sent_items < ITEM_GOAL) begin
      case ($urandom_range(0, 4))
        0:       maxp = '0;
        1:       maxp = 12'd4075;
        2:       maxp = MAXP_W'($urandom_range(0, 40));
        default: maxp = MAXP_W'($urandom_range(0, 4075));
      endcase
      write_config(pick_byte(), pick_byte(), pick_byte(), maxp);
      random_slot();
      wait_quiet();
    end

    if (board.fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
